// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the sequencer modules.
// Each macro takes a label, a clock, an active-low reset and the checked terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/i2cseq_pkg.sv -----
// Types and codes of the I2C master transaction sequencer.
// Used by the sequencer engine and the top level; depends on nothing.
package i2cseq_pkg;

	localparam logic [2:0] MODE_LOAD   = 3'd0;
	localparam logic [2:0] MODE_START  = 3'd1;
	localparam logic [2:0] MODE_STATUS = 3'd2;
	localparam logic [2:0] MODE_TICK   = 3'd3;
	localparam logic [2:0] MODE_FETCH  = 3'd4;

	localparam logic [7:0] STATUS_MASK  = 8'hF8;
	localparam logic [7:0] ST_BUS_ERROR = 8'h00;
	localparam logic [7:0] ST_START     = 8'h08;
	localparam logic [7:0] ST_REP_START = 8'h10;
	localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
	localparam logic [7:0] ST_SLAW_NACK = 8'h20;
	localparam logic [7:0] ST_DATA_ACK  = 8'h28;
	localparam logic [7:0] ST_DATA_NACK = 8'h30;
	localparam logic [7:0] ST_ARB_LOST  = 8'h38;
	localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
	localparam logic [7:0] ST_SLAR_NACK = 8'h48;
	localparam logic [7:0] ST_RX_ACK    = 8'h50;
	localparam logic [7:0] ST_RX_NACK   = 8'h58;

	typedef enum logic [2:0] {
		RES_UNKNOWN = 3'd0,
		RES_OK      = 3'd1,
		RES_ARB     = 3'd2,
		RES_NACK    = 3'd3,
		RES_BUSERR  = 3'd4
	} res_code_t;

	typedef enum logic [7:0] {
		PH_STANDBY    = 8'b0000_0001,
		PH_START      = 8'b0000_0010,
		PH_BUSY       = 8'b0000_0100,
		PH_W_ADR_NACK = 8'b0000_1000,
		PH_R_ADR_NACK = 8'b0001_0000,
		PH_DATA_NACK  = 8'b0010_0000,
		PH_BUS_ERR    = 8'b0100_0000,
		PH_ARB_LOST   = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [6:0] slave_address;
		logic [3:0] write_count;
		logic [4:0] read_count;
		logic [7:0] data_byte;
		logic [3:0] byte_index;
		logic [7:0] status_code;
		logic [7:0] rx_byte;
	} item_t;

	// Bus control command, listed from the highest bit down.
	typedef struct packed {
		logic stop;
		logic start;
		logic ack;
		logic clear_flag;
		logic irq_enable;
		logic valid;
	} ctrl_t;

	// Result item, listed from the highest bit down.
	typedef struct packed {
		logic [7:0] read_byte;
		logic       ready_res;
		res_code_t  result_code;
		logic [7:0] tx_byte;
		logic       tx_valid;
		ctrl_t      ctrl;
		logic       accepted;
	} result_t;

	function automatic ctrl_t issue_cmd(input logic ie, input logic clr, input logic ack,
		input logic sta, input logic sto);
		ctrl_t c;
		c.valid      = 1'b1;
		c.irq_enable = ie;
		c.clear_flag = clr;
		c.ack        = ack;
		c.start      = sta;
		c.stop       = sto;
		return c;
	endfunction

endpackage

// ----- hdl/i2cseq_engine.sv -----
// Sequencer state, write and read buffers and the per-item transition logic.
// Depends on i2cseq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module i2cseq_engine #(
	parameter int WRITE_BUF_DEPTH = 16,
	parameter int READ_BUF_DEPTH  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                proc,
	input  i2cseq_pkg::item_t   item,
	input  logic                load,
	input  logic [3:0]          load_index,
	output i2cseq_pkg::result_t res
);

	localparam int WA  = $clog2(WRITE_BUF_DEPTH);
	localparam int SCW = $clog2(WRITE_BUF_DEPTH + 1);
	localparam int RA  = (READ_BUF_DEPTH > 1) ? $clog2(READ_BUF_DEPTH) : 1;
	localparam int RCW = $clog2(READ_BUF_DEPTH + 1);

	i2cseq_pkg::phase_t    phase_q, phase_d;
	i2cseq_pkg::res_code_t result_q, result_d;
	logic                  irq_q, irq_d;
	logic [SCW-1:0]        sent_q, sent_d, stot_q, stot_d, sent_base;
	logic [RCW-1:0]        rcvd_q, rcvd_d, rtot_q, rtot_d, rcvd_nxt;
	logic [7:0]            addr_q, addr_d;

	logic [7:0]    wbuf [WRITE_BUF_DEPTH];
	logic [7:0]    rbuf [READ_BUF_DEPTH];
	logic [7:0]    wb_rd_q, rb_rd_q;
	logic          wb_we, rb_we;
	logic [WA-1:0] wb_wa, wb_ra;
	logic [RA-1:0] rb_wa, rb_ra;
	logic [8:0]    wpos;
	logic [7:0]    code;

	assign wpos  = 9'(item.byte_index) + 9'd1;
	assign code  = item.status_code & i2cseq_pkg::STATUS_MASK;
	assign wb_wa = wpos[WA-1:0];
	assign wb_ra = sent_d[WA-1:0];
	assign rb_wa = rcvd_q[RA-1:0];
	assign rb_ra = RA'(load_index);

	always_comb begin
		phase_d   = phase_q;
		result_d  = result_q;
		irq_d     = irq_q;
		sent_d    = sent_q;
		stot_d    = stot_q;
		rcvd_d    = rcvd_q;
		rtot_d    = rtot_q;
		addr_d    = addr_q;
		wb_we     = 1'b0;
		rb_we     = 1'b0;
		rcvd_nxt  = rcvd_q;
		sent_base = (code == i2cseq_pkg::ST_START || code == i2cseq_pkg::ST_REP_START) ?
			'0 : sent_q;
		res       = '0;
		if (proc) begin
			case (item.mode)
				i2cseq_pkg::MODE_LOAD: begin
					if (wpos < 9'(WRITE_BUF_DEPTH)) begin
						wb_we = 1'b1;
					end
				end
				i2cseq_pkg::MODE_START: begin
					if (!irq_q && 9'(item.write_count) <= 9'(WRITE_BUF_DEPTH - 1) &&
						9'(item.read_count) <= 9'(READ_BUF_DEPTH)) begin
						stot_d       = SCW'(9'(item.write_count) + 9'd1);
						rtot_d       = RCW'(item.read_count);
						sent_d       = '0;
						rcvd_d       = '0;
						addr_d       = {item.slave_address, item.read_count != 5'd0};
						result_d     = i2cseq_pkg::RES_UNKNOWN;
						phase_d      = i2cseq_pkg::PH_START;
						res.accepted = 1'b1;
					end
				end
				i2cseq_pkg::MODE_STATUS: begin
					if (irq_q) begin
						if (code inside {i2cseq_pkg::ST_START, i2cseq_pkg::ST_REP_START,
							i2cseq_pkg::ST_SLAW_ACK, i2cseq_pkg::ST_DATA_ACK}) begin
							if (code == i2cseq_pkg::ST_START || code == i2cseq_pkg::ST_REP_START) begin
								rcvd_d = '0;
							end
							if (sent_base < stot_q) begin
								res.tx_valid = 1'b1;
								res.tx_byte  = (sent_base == '0) ? addr_q : wb_rd_q;
								sent_d       = sent_base + SCW'(1);
								res.ctrl     = i2cseq_pkg::issue_cmd(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
							end else begin
								sent_d   = sent_base;
								res.ctrl = i2cseq_pkg::issue_cmd(1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
								result_d = i2cseq_pkg::RES_OK;
								phase_d  = i2cseq_pkg::PH_STANDBY;
							end
						end else if (code inside {i2cseq_pkg::ST_RX_ACK, i2cseq_pkg::ST_SLAR_ACK}) begin
							if (code == i2cseq_pkg::ST_RX_ACK && rcvd_q < rtot_q) begin
								rb_we    = 1'b1;
								rcvd_nxt = rcvd_q + RCW'(1);
							end
							rcvd_d   = rcvd_nxt;
							res.ctrl = i2cseq_pkg::issue_cmd(1'b1, 1'b1, rcvd_nxt < rtot_q, 1'b0, 1'b0);
						end else if (code == i2cseq_pkg::ST_RX_NACK) begin
							res.ctrl = i2cseq_pkg::issue_cmd(1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
							result_d = i2cseq_pkg::RES_OK;
							phase_d  = i2cseq_pkg::PH_STANDBY;
						end else if (code == i2cseq_pkg::ST_ARB_LOST) begin
							res.ctrl = i2cseq_pkg::issue_cmd(1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
							result_d = i2cseq_pkg::RES_ARB;
							phase_d  = i2cseq_pkg::PH_ARB_LOST;
						end else if (code inside {i2cseq_pkg::ST_SLAW_NACK, i2cseq_pkg::ST_SLAR_NACK,
							i2cseq_pkg::ST_DATA_NACK}) begin
							res.ctrl = i2cseq_pkg::issue_cmd(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
							result_d = i2cseq_pkg::RES_NACK;
							phase_d  = (code == i2cseq_pkg::ST_SLAW_NACK) ? i2cseq_pkg::PH_W_ADR_NACK :
								(code == i2cseq_pkg::ST_SLAR_NACK) ? i2cseq_pkg::PH_R_ADR_NACK :
								i2cseq_pkg::PH_DATA_NACK;
						end else if (code == i2cseq_pkg::ST_BUS_ERROR) begin
							res.ctrl = i2cseq_pkg::issue_cmd(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
							result_d = i2cseq_pkg::RES_BUSERR;
							phase_d  = i2cseq_pkg::PH_BUS_ERR;
						end else begin
							res.ctrl = i2cseq_pkg::issue_cmd(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
							phase_d  = i2cseq_pkg::PH_STANDBY;
						end
						irq_d = res.ctrl.irq_enable;
					end
				end
				i2cseq_pkg::MODE_TICK: begin
					case (phase_q)
						i2cseq_pkg::PH_START: begin
							res.ctrl = i2cseq_pkg::issue_cmd(1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
							irq_d    = 1'b1;
							phase_d  = i2cseq_pkg::PH_BUSY;
						end
						i2cseq_pkg::PH_W_ADR_NACK, i2cseq_pkg::PH_R_ADR_NACK,
						i2cseq_pkg::PH_DATA_NACK, i2cseq_pkg::PH_BUS_ERR: begin
							res.ctrl = i2cseq_pkg::issue_cmd(1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
							irq_d    = 1'b1;
							phase_d  = i2cseq_pkg::PH_START;
						end
						default: begin
						end
					endcase
				end
				i2cseq_pkg::MODE_FETCH: begin
					if (phase_q == i2cseq_pkg::PH_STANDBY && result_q == i2cseq_pkg::RES_OK &&
						9'(item.byte_index) < 9'(rcvd_q) &&
						9'(item.byte_index) < 9'(READ_BUF_DEPTH)) begin
						res.accepted  = 1'b1;
						res.read_byte = rb_rd_q;
					end
				end
				default: begin
				end
			endcase
		end
		res.result_code = result_d;
		res.ready_res   = (phase_d == i2cseq_pkg::PH_STANDBY);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= i2cseq_pkg::PH_STANDBY;
			result_q <= i2cseq_pkg::RES_UNKNOWN;
			irq_q    <= 1'b0;
			sent_q   <= '0;
			stot_q   <= '0;
			rcvd_q   <= '0;
			rtot_q   <= '0;
		end else begin
			phase_q  <= phase_d;
			result_q <= result_d;
			irq_q    <= irq_d;
			sent_q   <= sent_d;
			stot_q   <= stot_d;
			rcvd_q   <= rcvd_d;
			rtot_q   <= rtot_d;
		end
	end

	always_ff @(posedge clk) begin
		addr_q <= addr_d;
	end

	// The write buffer keeps the entry at the next send position ready, with write bypass.
	always_ff @(posedge clk) begin
		if (wb_we) begin
			wbuf[wb_wa] <= item.data_byte;
		end
		wb_rd_q <= (wb_we && wb_wa == wb_ra) ? item.data_byte : wbuf[wb_ra];
	end

	// The read buffer is read whenever any item enters the input register.
	always_ff @(posedge clk) begin
		if (rb_we) begin
			rbuf[rb_wa] <= item.rx_byte;
		end
		if (load) begin
			rb_rd_q <= (rb_we && rb_wa == rb_ra) ? item.rx_byte : rbuf[rb_ra];
		end
	end

	`ASSERT_IMPLIES(a_irq_not_standby, clk, arst_n, irq_q, phase_q != i2cseq_pkg::PH_STANDBY, "interrupts enabled in standby")
	`ASSERT_IMPLIES(a_sent_bound, clk, arst_n, 1'b1, sent_q <= stot_q, "sent count beyond send total")
	`ASSERT_IMPLIES(a_rcvd_bound, clk, arst_n, 1'b1, rcvd_q <= rtot_q, "received count beyond receive total")

endmodule

// ----- hdl/i2c_master_transaction_sequencer_core.sv -----
// Top level of the I2C master transaction sequencer: stream ports, input
// register and result register around i2cseq_engine. Depends on i2cseq_pkg.
// An accepted item is held in the input register, and its result in the result register.
// Throughput: one item per cycle while the result side is not stalled; one pass of the engine logic per item.
// Backpressure on the result side holds the result register, stops the engine and stalls the input register.
// Reset clears phase, counters, result code and valid flags; the buffers are not reset.
`include "assert_macros.svh"

module i2c_master_transaction_sequencer_core #(
	parameter int WRITE_BUF_DEPTH = 16,
	parameter int READ_BUF_DEPTH  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// slave_address[6:0], write_count[10:7], read_count[15:11], data_byte[23:16],
	// byte_index[27:24], status_code[35:28], rx_byte[43:36], zero fill[47:44]
	input  logic [47:0] s_tdata,
	// mode[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// accepted[0], ctrl_valid[1], ctrl_irq_enable[2], ctrl_clear_flag[3], ctrl_ack[4],
	// ctrl_start[5], ctrl_stop[6], tx_valid[7], tx_byte[15:8], result_code[18:16],
	// ready_res[19], read_byte[27:20], zero fill[31:28]
	output logic [31:0] m_tdata
);

	i2cseq_pkg::item_t   item_in, item_s1;
	i2cseq_pkg::result_t res, res_s2;
	logic                valid_s1, valid_s2, adv, load;

	always_comb begin
		item_in.mode          = s_tuser;
		item_in.slave_address = s_tdata[6:0];
		item_in.write_count   = s_tdata[10:7];
		item_in.read_count    = s_tdata[15:11];
		item_in.data_byte     = s_tdata[23:16];
		item_in.byte_index    = s_tdata[27:24];
		item_in.status_code   = s_tdata[35:28];
		item_in.rx_byte       = s_tdata[43:36];
	end

	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign load     = s_tvalid && s_tready;
	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'd0, res_s2};

	i2cseq_engine #(
		.WRITE_BUF_DEPTH(WRITE_BUF_DEPTH),
		.READ_BUF_DEPTH (READ_BUF_DEPTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.proc      (adv),
		.item      (item_s1),
		.load      (load),
		.load_index(item_in.byte_index),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item_in;
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

	`ASSERT_NEXT(a_adv_gives_result, clk, arst_n, adv, m_tvalid, "processed item gave no result")
	`ASSERT_IMPLIES(a_no_lost_item, clk, arst_n, valid_s1 && !s_tready, valid_s2 && !m_tready, "input held without a stalled result")
	`ASSERT_IMPLIES(a_tx_zero, clk, arst_n, m_tvalid && !m_tdata[7], m_tdata[15:8] == 8'd0, "tx byte set without tx valid")

endmodule
